// ===== design/assert_macros.svh =====
// shared assertion macros, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// cond holds at every edge
`define ASSERT_ALW(label, cond) `ASSERT_IMP(label, 1'b1, cond)

`endif

// ===== design/tcw_pkg.sv =====
package tcw_pkg;

    localparam int LOC_W  = 11;
    localparam int CELL_W = 16;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SET   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [CELL_W-1:0] BLANK_CELL        = 16'h0F20;
    localparam logic [BYTE_W-1:0] DEFAULT_COLOR_RST = 8'h0F;

    // tab stops every 2**TAB_STOP_W columns
    localparam int TAB_STOP_W = 3;

    typedef struct packed {
        logic put;
        logic scroll;
        logic clear;
        logic read;
    } seq_cmd_t;

endpackage

// ===== design/tcw_in_if.sv =====
interface tcw_in_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] character;
    logic [BYTE_W-1:0] color;
    logic              use_default;
    logic [BYTE_W-1:0] column;
    logic [BYTE_W-1:0] row;

    modport source (output valid, op, character, color, use_default, column, row,
                    input ready);
    modport sink   (input valid, op, character, color, use_default, column, row,
                    output ready);
endinterface

// ===== design/tcw_out_if.sv =====
interface tcw_out_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LOC_W-1:0]  cursor_location;
    logic [CELL_W-1:0] cell_value;

    modport source (output valid, cursor_location, cell_value, input ready);
    modport sink   (input valid, cursor_location, cell_value, output ready);
endinterface

// ===== design/tcw_ram.sv =====
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tcw_cursor.sv =====
`include "assert_macros.svh"

module tcw_cursor import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    localparam int ADDR_W = $clog2(COLUMNS * ROWS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [OP_W-1:0]   op,
    input  logic [BYTE_W-1:0] character,
    input  logic [BYTE_W-1:0] column,
    input  logic [BYTE_W-1:0] row,
    output seq_cmd_t          cmd,
    output logic [ADDR_W-1:0] put_addr,
    output logic [ADDR_W-1:0] read_addr,
    output logic [LOC_W-1:0]  loc_now,
    output logic [LOC_W-1:0]  loc_next
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int CX_W  = COL_W + 1;
    localparam int RX_W  = ROW_W + 1;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [CX_W-1:0]  col_ext, col_step, tab_sum;
    logic             row_inc, put_char, wrap, last_row, scroll;
    logic [COL_W-1:0] put_col;
    logic [ROW_W-1:0] put_row;
    logic [COL_W-1:0] col_clamp;
    logic [ROW_W-1:0] row_clamp;
    logic [ADDR_W-1:0] cur_addr, next_addr;

    // put-character cursor movement
    always_comb
    begin
        col_ext  = {1'b0, col_reg};
        tab_sum  = col_ext + CX_W'(1 << TAB_STOP_W);
        col_step = col_ext;
        row_inc  = 1'b0;
        put_char = 1'b0;
        case (character)
            CH_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    col_step = col_ext - CX_W'(1);
                end
            end
            CH_TAB:
            begin
                col_step = {tab_sum[CX_W-1:TAB_STOP_W], {TAB_STOP_W{1'b0}}};
            end
            CH_CR:
            begin
                col_step = '0;
            end
            CH_LF:
            begin
                col_step = '0;
                row_inc  = 1'b1;
            end
            default:
            begin
                // bytes 0x20 to 0x7f only, top-bit bytes are dropped
                if (character >= CH_SPACE && !character[BYTE_W-1])
                begin
                    put_char = 1'b1;
                    col_step = col_ext + CX_W'(1);
                end
            end
        endcase
        wrap = col_step >= CX_W'(COLUMNS);
        if (wrap)
        begin
            row_inc = 1'b1;
        end
        last_row = row_reg == ROW_W'(ROWS - 1);
        scroll   = row_inc && last_row;
        put_col  = wrap ? '0 : col_step[COL_W-1:0];
        put_row  = (row_inc && !last_row) ? row_reg + ROW_W'(1) : row_reg;
    end

    assign col_clamp = (column > BYTE_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1)
                                                       : column[COL_W-1:0];
    assign row_clamp = (row > BYTE_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : row[ROW_W-1:0];

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        cmd      = '0;
        case (op)
            OP_PUT:
            begin
                col_next   = put_col;
                row_next   = put_row;
                cmd.put    = accept && put_char;
                cmd.scroll = accept && scroll;
            end
            OP_CLEAR:
            begin
                col_next  = '0;
                row_next  = '0;
                cmd.clear = accept;
            end
            OP_SET:
            begin
                col_next = col_clamp;
                row_next = row_clamp;
            end
            OP_READ:
            begin
                cmd.read = accept;
            end
            default:
            begin
                col_next = col_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign cur_addr  = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign next_addr = ADDR_W'(row_next) * ADDR_W'(COLUMNS) + ADDR_W'(col_next);
    assign read_addr = ADDR_W'(row_clamp) * ADDR_W'(COLUMNS) + ADDR_W'(col_clamp);
    assign put_addr  = cur_addr;
    assign loc_now   = LOC_W'(cur_addr);
    assign loc_next  = LOC_W'(next_addr);

    `ASSERT_ALW(cursor_in_range, ({1'b0, col_reg} < CX_W'(COLUMNS)) && ({1'b0, row_reg} < RX_W'(ROWS)))

endmodule

// ===== design/tcw_seq.sv =====
`include "assert_macros.svh"

module tcw_seq import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    localparam int CELLS  = COLUMNS * ROWS,
    localparam int ADDR_W = $clog2(CELLS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  seq_cmd_t          cmd,
    input  logic [ADDR_W-1:0] put_addr,
    input  logic [CELL_W-1:0] put_data,
    input  logic [ADDR_W-1:0] read_addr,
    output logic              busy,
    output logic              rd_done,
    output logic [CELL_W-1:0] rd_data
);

    localparam int CNT_W = $clog2(CELLS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_COPY = 4'b0010,
        S_FILL = 4'b0100,
        S_READ = 4'b1000
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic              pend_reg, pend_next;
    logic              fetch;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        pend_next   = 1'b0;
        fetch       = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = wr_ptr_reg;
        ram_wdata   = BLANK_CELL;
        ram_raddr   = read_addr;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.put)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = put_addr;
                    ram_wdata = put_data;
                end
                if (cmd.clear)
                begin
                    state_next  = S_FILL;
                    wr_ptr_next = '0;
                end
                else if (cmd.scroll)
                begin
                    state_next  = S_COPY;
                    rd_ptr_next = CNT_W'(COLUMNS);
                    wr_ptr_next = '0;
                end
                else if (cmd.read)
                begin
                    state_next = S_READ;
                end
            end
            S_COPY:
            begin
                // read one row ahead, write back the word fetched last cycle
                ram_raddr = rd_ptr_reg[ADDR_W-1:0];
                fetch     = rd_ptr_reg != CNT_W'(CELLS);
                pend_next = fetch;
                if (fetch)
                begin
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    ram_we      = 1'b1;
                    ram_wdata   = ram_rdata;
                    wr_ptr_next = wr_ptr_reg + ADDR_W'(1);
                end
                if (!fetch && !pend_reg)
                begin
                    // write pointer now sits at the start of the bottom row
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                ram_we = 1'b1;
                if (wr_ptr_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    wr_ptr_next = wr_ptr_reg + ADDR_W'(1);
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // out of reset the whole screen is swept to blanks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_FILL;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            pend_reg   <= pend_next;
        end
    end

    assign busy    = state_reg != S_IDLE;
    assign rd_done = state_reg == S_READ;
    assign rd_data = ram_rdata;

    `ASSERT_IMP(cmd_only_when_idle, cmd.put || cmd.scroll || cmd.clear || cmd.read, state_reg == S_IDLE)
    `ASSERT_IMP(copy_lead, (state_reg == S_COPY) && pend_reg, rd_ptr_reg == CNT_W'(wr_ptr_reg) + CNT_W'(COLUMNS + 1))
    `ASSERT_NXT(fill_ends_idle, (state_reg == S_FILL) && (wr_ptr_reg == ADDR_W'(CELLS - 1)), state_reg == S_IDLE)

endmodule

// ===== design/text_console_writer_core.sv =====
// Text console writer: a COLUMNS x ROWS screen of 16-bit cells (attribute
// byte high, character byte low) with a cursor, held in one block RAM.
// in_ch takes one word per operation: put character, clear screen, set
// cursor or read cell. out_ch returns one word per operation with the
// cursor location after it and, for a read, the cell contents.
// cfg_wr_en/cfg_wr_data load the default attribute byte, used when
// use_default is set; write it only while the block is idle.
// Put character and set cursor words are taken at one per cycle, back to
// back, while the output drains; a read holds off input for the RAM read.
// A put that scrolls holds off input while the copy state moves every row
// but the top one up by a row and the fill state blanks the bottom row,
// the RAM port moving one cell per cycle. A clear holds off input while
// the fill state blanks every cell. After reset the screen is swept to
// blanks with ready low; the cursor returns to the top-left and the
// default attribute to 0x0F. A stalled output word is held in its
// register; one more operation is taken meanwhile only if the word is
// drained in that cycle.
module text_console_writer_core import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    tcw_in_if.sink            in_ch,
    tcw_out_if.source         out_ch,
    input  logic              cfg_wr_en,
    input  logic [BYTE_W-1:0] cfg_wr_data
);

    localparam int ADDR_W = $clog2(COLUMNS * ROWS);

    logic [BYTE_W-1:0] default_color_reg;
    logic              out_valid_reg;
    logic [LOC_W-1:0]  loc_reg;
    logic [CELL_W-1:0] cell_reg;

    logic              accept;
    logic              seq_busy, rd_done;
    seq_cmd_t          cmd;
    logic [ADDR_W-1:0] put_addr, read_addr;
    logic [LOC_W-1:0]  loc_now, loc_next;
    logic [CELL_W-1:0] put_data, rd_data;
    logic [BYTE_W-1:0] attr;

    assign in_ch.ready = !seq_busy && (!out_valid_reg || out_ch.ready);
    assign accept      = in_ch.valid && in_ch.ready;
    assign attr        = in_ch.use_default ? default_color_reg : in_ch.color;
    assign put_data    = {attr, in_ch.character};

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (in_ch.op),
        .character (in_ch.character),
        .column    (in_ch.column),
        .row       (in_ch.row),
        .cmd       (cmd),
        .put_addr  (put_addr),
        .read_addr (read_addr),
        .loc_now   (loc_now),
        .loc_next  (loc_next)
    );

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .put_addr  (put_addr),
        .put_data  (put_data),
        .read_addr (read_addr),
        .busy      (seq_busy),
        .rd_done   (rd_done),
        .rd_data   (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_color_reg <= DEFAULT_COLOR_RST;
        end
        else if (cfg_wr_en)
        begin
            default_color_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((accept && !cmd.read) || rd_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // a read word is loaded when the RAM data returns, the rest on acceptance
    always_ff @(posedge clk)
    begin
        if (accept && !cmd.read)
        begin
            loc_reg  <= loc_next;
            cell_reg <= '0;
        end
        else if (rd_done)
        begin
            loc_reg  <= loc_now;
            cell_reg <= rd_data;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.cursor_location = loc_reg;
    assign out_ch.cell_value      = cell_reg;

    `ASSERT_IMP(read_slot_free, rd_done, !out_valid_reg)

endmodule
